### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every clock edge
`define DPAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition in one cycle requires a condition in the next
`define DPAT_ASSERT_NEXT(lbl, cond, nxt, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (nxt)) \
    else $error(msg);

`endif

### rtl/dpat_pkg.sv
// ----------------------------------------------------------------------------
// dpat_pkg
// shared constants and controller/datapath interface types
// ----------------------------------------------------------------------------
package dpat_pkg;

  localparam int unsigned MAX_PAGES = 1024;
  localparam int unsigned PAGE_W    = 10;
  localparam int unsigned USED_W    = 11;
  localparam int unsigned BUCKETS   = 1024;
  localparam int unsigned BKT_W     = 10;
  localparam int unsigned OWNER_W   = 30;
  localparam int unsigned SPACE_MUL = 23;
  localparam logic [4:0]  MIN_LOG   = 5'd10;
  localparam logic [4:0]  MAX_LOG   = 5'd16;
  localparam logic [4:0]  LOG_RESET = 5'd12;

  localparam logic [2:0] REG_PAGE_LOG = 3'd0;

  localparam logic [1:0] MODE_XLATE  = 2'd0;
  localparam logic [1:0] MODE_RECORD = 2'd1;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_EXEC  = 2'd2;

  localparam logic [1:0] ST_HIT      = 2'd0;
  localparam logic [1:0] ST_NEW      = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_UNMAPPED = 2'd3;

  typedef struct packed {
    logic       load;
    logic       clr;
    logic       probe;
    logic       from_head;
    logic       alloc;
    logic       cnt_upd;
    logic       res_valid;
    logic [1:0] res_status;
    logic       res_xlate;
    logic       res_new;
    logic       res_counts;
  } cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       head_empty;
    logic       link_end;
    logic       match;
    logic       full;
    logic       page_ok;
    logic [1:0] mode;
  } sts_t;

endpackage

### rtl/dpat_ram.sv
// ----------------------------------------------------------------------------
// dpat_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module dpat_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/dpat_ctrl.sv
// ----------------------------------------------------------------------------
// dpat_ctrl
// sequencer for bucket clear, chain walk, allocation and counter access
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dpat_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  dpat_pkg::sts_t sts_i,
  output dpat_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_HEAD,
    S_PROBE,
    S_ALLOC,
    S_CREAD,
    S_CDATA
  } state_e;

  state_e state_q, state_d;
  dpat_pkg::cmd_t cmd;
  logic walk_st;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    case (state_q)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd.load = 1'b1;
          state_d  = S_HASH;
        end
      end
      S_HASH: state_d = (sts_i.mode == dpat_pkg::MODE_XLATE) ? S_HEAD : S_CREAD;
      S_HEAD: begin
        if (!sts_i.head_empty) begin
          cmd.probe     = 1'b1;
          cmd.from_head = 1'b1;
          state_d       = S_PROBE;
        end else if (sts_i.full) begin
          cmd.res_valid  = 1'b1;
          cmd.res_status = dpat_pkg::ST_FULL;
          state_d        = S_IDLE;
        end else begin
          state_d = S_ALLOC;
        end
      end
      S_PROBE: begin
        if (sts_i.match) begin
          cmd.res_valid  = 1'b1;
          cmd.res_status = dpat_pkg::ST_HIT;
          cmd.res_xlate  = 1'b1;
          state_d        = S_IDLE;
        end else if (!sts_i.link_end) begin
          cmd.probe = 1'b1;
        end else if (sts_i.full) begin
          cmd.res_valid  = 1'b1;
          cmd.res_status = dpat_pkg::ST_FULL;
          state_d        = S_IDLE;
        end else begin
          state_d = S_ALLOC;
        end
      end
      S_ALLOC: begin
        cmd.alloc      = 1'b1;
        cmd.res_valid  = 1'b1;
        cmd.res_status = dpat_pkg::ST_NEW;
        cmd.res_xlate  = 1'b1;
        cmd.res_new    = 1'b1;
        state_d        = S_IDLE;
      end
      S_CREAD: begin
        if (sts_i.page_ok) begin
          state_d = S_CDATA;
        end else begin
          cmd.res_valid  = 1'b1;
          cmd.res_status = dpat_pkg::ST_UNMAPPED;
          state_d        = S_IDLE;
        end
      end
      S_CDATA: begin
        cmd.cnt_upd    = (sts_i.mode == dpat_pkg::MODE_RECORD);
        cmd.res_valid  = 1'b1;
        cmd.res_status = dpat_pkg::ST_HIT;
        cmd.res_counts = 1'b1;
        state_d        = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o  = (state_q != S_IDLE);
  assign cmd_o   = cmd;
  assign walk_st = (state_q == S_HEAD) || (state_q == S_PROBE);

  `DPAT_ASSERT(a_alloc_not_full, (state_q == S_ALLOC) |-> !sts_i.full, "alloc while full")
  `DPAT_ASSERT_NEXT(a_res_then_idle, cmd.res_valid, state_q == S_IDLE, "no idle after result")
  `DPAT_ASSERT(a_probe_order, (state_q == S_PROBE) |-> $past(walk_st), "probe without head read")

endmodule

### rtl/dpat_dp.sv
// ----------------------------------------------------------------------------
// dpat_dp
// request registers, hashed page table memories, counters and result registers
// ----------------------------------------------------------------------------
module dpat_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [4:0]     page_size_log2_i,
  input  logic [1:0]     mode_i,
  input  logic [7:0]     space_id_i,
  input  logic [31:0]    virt_addr_i,
  input  logic [31:0]    phys_addr_i,
  input  logic [1:0]     access_kind_i,
  input  dpat_pkg::cmd_t cmd_i,
  output dpat_pkg::sts_t sts_o,
  output logic           done_o,
  output logic [31:0]    result_addr_o,
  output logic [1:0]     status_o,
  output logic [31:0]    read_total_o,
  output logic [31:0]    write_total_o,
  output logic [31:0]    exec_total_o
);

  localparam int unsigned PW = dpat_pkg::PAGE_W;
  localparam int unsigned UW = dpat_pkg::USED_W;
  localparam int unsigned BW = dpat_pkg::BKT_W;

  logic [1:0]  mode_q, kind_q;
  logic [7:0]  space_q;
  logic [31:0] vaddr_q, paddr_q;
  logic [PW-1:0] page_q;
  logic [UW-1:0] used_q;
  logic [BW-1:0] clr_idx_q;
  logic        done_q;
  logic [31:0] addr_q, rd_tot_q, wr_tot_q, ex_tot_q;
  logic [1:0]  status_q;

  logic [4:0]  lg;
  logic [31:0] mask, vpn, ppage;
  logic [12:0] space_mul;
  logic [BW-1:0] bucket;
  logic [dpat_pkg::OWNER_W-1:0] owner_tag, owner_rd;
  logic [UW-1:0] head_rd, link_rd;
  logic [PW-1:0] probe_addr, res_page;
  logic [31:0] rd_cnt, wr_cnt, ex_cnt, rd_new, wr_new, ex_new;
  logic        head_we;
  logic [BW-1:0] head_waddr;
  logic [UW-1:0] head_wdata;
  logic        rd_we, wr_we, ex_we;
  logic [PW-1:0] cnt_waddr;

  always_comb begin
    if (page_size_log2_i < dpat_pkg::MIN_LOG) begin
      lg = dpat_pkg::MIN_LOG;
    end else if (page_size_log2_i > dpat_pkg::MAX_LOG) begin
      lg = dpat_pkg::MAX_LOG;
    end else begin
      lg = page_size_log2_i;
    end
  end

  assign mask      = (32'd1 << lg) - 32'd1;
  assign vpn       = vaddr_q >> lg;
  assign ppage     = paddr_q >> lg;
  assign space_mul = {5'd0, space_q} * 13'(dpat_pkg::SPACE_MUL);
  assign bucket    = vpn[BW-1:0] + space_mul[BW-1:0];
  assign owner_tag = {space_q, vaddr_q[31:10] & ~mask[31:10]};

  assign probe_addr = cmd_i.from_head ? PW'(head_rd - UW'(1)) : PW'(link_rd - UW'(1));

  // bucket heads: cleared by a sweep after reset
  assign head_we    = cmd_i.clr | cmd_i.alloc;
  assign head_waddr = cmd_i.clr ? clr_idx_q : bucket;
  assign head_wdata = cmd_i.clr ? '0 : used_q + UW'(1);

  dpat_ram #(.WIDTH(UW), .DEPTH(dpat_pkg::BUCKETS)) u_head (
    .clk_i, .we_i(head_we), .waddr_i(head_waddr), .wdata_i(head_wdata),
    .raddr_i(bucket), .rdata_o(head_rd)
  );

  dpat_ram #(.WIDTH(dpat_pkg::OWNER_W), .DEPTH(dpat_pkg::MAX_PAGES)) u_owner (
    .clk_i, .we_i(cmd_i.alloc), .waddr_i(used_q[PW-1:0]), .wdata_i(owner_tag),
    .raddr_i(probe_addr), .rdata_o(owner_rd)
  );

  dpat_ram #(.WIDTH(UW), .DEPTH(dpat_pkg::MAX_PAGES)) u_link (
    .clk_i, .we_i(cmd_i.alloc), .waddr_i(used_q[PW-1:0]), .wdata_i(head_rd),
    .raddr_i(probe_addr), .rdata_o(link_rd)
  );

  // access counters
  always_comb begin
    rd_new = rd_cnt;
    wr_new = wr_cnt;
    ex_new = ex_cnt;
    if (cmd_i.cnt_upd) begin
      case (kind_q)
        dpat_pkg::KIND_READ:  rd_new = (&rd_cnt) ? rd_cnt : rd_cnt + 32'd1;
        dpat_pkg::KIND_WRITE: wr_new = (&wr_cnt) ? wr_cnt : wr_cnt + 32'd1;
        dpat_pkg::KIND_EXEC:  ex_new = (&ex_cnt) ? ex_cnt : ex_cnt + 32'd1;
        default: ;
      endcase
    end
  end

  assign rd_we     = cmd_i.alloc | (cmd_i.cnt_upd && kind_q == dpat_pkg::KIND_READ);
  assign wr_we     = cmd_i.alloc | (cmd_i.cnt_upd && kind_q == dpat_pkg::KIND_WRITE);
  assign ex_we     = cmd_i.alloc | (cmd_i.cnt_upd && kind_q == dpat_pkg::KIND_EXEC);
  assign cnt_waddr = cmd_i.alloc ? used_q[PW-1:0] : ppage[PW-1:0];

  dpat_ram #(.WIDTH(32), .DEPTH(dpat_pkg::MAX_PAGES)) u_rd_cnt (
    .clk_i, .we_i(rd_we), .waddr_i(cnt_waddr), .wdata_i(cmd_i.alloc ? 32'd0 : rd_new),
    .raddr_i(ppage[PW-1:0]), .rdata_o(rd_cnt)
  );

  dpat_ram #(.WIDTH(32), .DEPTH(dpat_pkg::MAX_PAGES)) u_wr_cnt (
    .clk_i, .we_i(wr_we), .waddr_i(cnt_waddr), .wdata_i(cmd_i.alloc ? 32'd0 : wr_new),
    .raddr_i(ppage[PW-1:0]), .rdata_o(wr_cnt)
  );

  dpat_ram #(.WIDTH(32), .DEPTH(dpat_pkg::MAX_PAGES)) u_ex_cnt (
    .clk_i, .we_i(ex_we), .waddr_i(cnt_waddr), .wdata_i(cmd_i.alloc ? 32'd0 : ex_new),
    .raddr_i(ppage[PW-1:0]), .rdata_o(ex_cnt)
  );

  assign res_page = cmd_i.res_new ? used_q[PW-1:0] : page_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      clr_idx_q <= '0;
      done_q    <= 1'b0;
    end else begin
      done_q <= cmd_i.res_valid;
      if (cmd_i.clr) begin
        clr_idx_q <= clr_idx_q + BW'(1);
      end
      if (cmd_i.alloc) begin
        used_q <= used_q + UW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= mode_i;
      space_q <= space_id_i;
      vaddr_q <= virt_addr_i;
      paddr_q <= phys_addr_i;
      kind_q  <= access_kind_i;
    end
    if (cmd_i.probe) begin
      page_q <= probe_addr;
    end
    if (cmd_i.res_valid) begin
      status_q <= cmd_i.res_status;
      addr_q   <= cmd_i.res_xlate ? (({22'd0, res_page} << lg) | (vaddr_q & mask)) : 32'd0;
      rd_tot_q <= cmd_i.res_counts ? rd_new : 32'd0;
      wr_tot_q <= cmd_i.res_counts ? wr_new : 32'd0;
      ex_tot_q <= cmd_i.res_counts ? ex_new : 32'd0;
    end
  end

  assign sts_o.clr_last   = &clr_idx_q;
  assign sts_o.head_empty = (head_rd == '0);
  assign sts_o.link_end   = (link_rd == '0);
  assign sts_o.match      = (owner_rd == owner_tag);
  assign sts_o.full       = (used_q >= UW'(dpat_pkg::MAX_PAGES));
  assign sts_o.page_ok    = (ppage < {21'd0, used_q});
  assign sts_o.mode       = mode_q;

  assign done_o        = done_q;
  assign result_addr_o = addr_q;
  assign status_o      = status_q;
  assign read_total_o  = rd_tot_q;
  assign write_total_o = wr_tot_q;
  assign exec_total_o  = ex_tot_q;

endmodule

### rtl/demand_paged_address_translator.sv
// ----------------------------------------------------------------------------
// demand_paged_address_translator
// hashed page table translator with per-page access counters and apb config
// ----------------------------------------------------------------------------
// one request at a time, next start taken in the done_o cycle; a translate
//   reads the bucket head, walks the chain entry by entry and ends in a hit,
//   an allocation or table full; record/query reads the counters of the page,
//   or reports an unmapped page
// after reset a sweep clears all 1024 bucket heads with busy high
// done_o pulses one cycle; the receiver cannot stall
module demand_paged_address_translator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  output logic        done_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  space_id_i,
  input  logic [31:0] virt_addr_i,
  input  logic [31:0] phys_addr_i,
  input  logic [1:0]  access_kind_i,
  output logic [31:0] result_addr_o,
  output logic [1:0]  status_o,
  output logic [31:0] read_total_o,
  output logic [31:0] write_total_o,
  output logic [31:0] exec_total_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [4:0] page_log_q;
  logic       busy_w;
  dpat_pkg::cmd_t cmd;
  dpat_pkg::sts_t sts;

  assign pready = 1'b1;
  assign prdata = (paddr == dpat_pkg::REG_PAGE_LOG) ? {27'd0, page_log_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_log_q <= dpat_pkg::LOG_RESET;
    end else if (psel && penable && pwrite && pready && paddr == dpat_pkg::REG_PAGE_LOG) begin
      page_log_q <= pwdata[4:0];
    end
  end

  dpat_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy_w), .sts_i(sts), .cmd_o(cmd)
  );

  dpat_dp u_dp (
    .clk_i, .rst_ni,
    .page_size_log2_i(page_log_q),
    .mode_i, .space_id_i, .virt_addr_i, .phys_addr_i, .access_kind_i,
    .cmd_i(cmd), .sts_o(sts),
    .done_o, .result_addr_o, .status_o, .read_total_o, .write_total_o, .exec_total_o
  );

  assign busy = busy_w;

endmodule
